[rtl/wpi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint path interpolator package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package wpi_pkg;

    localparam int MAX_STEPS_DEF = 63;
    localparam logic [30:0] STEP_RESET = 31'd3277;
    localparam logic signed [33:0] PI_Z = 34'sd52707179;
    localparam logic signed [33:0] HEAD_MAX = 34'sd25736;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQRT,
        S_DIV,
        S_NORM,
        S_CORDIC,
        S_EMIT_MUL,
        S_EMIT_DIV,
        S_EMIT_OUT,
        S_FINAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item and form dx, dy
        logic sqrt_init;  // start the square root
        logic sqrt_step;  // one square root iteration
        logic div_init;   // start distance / step length
        logic div_step;   // one divider iteration
        logic cor_init;   // set up the CORDIC vector
        logic norm_step;  // one doubling step
        logic cor_step;   // one CORDIC iteration
        logic emit_init;  // start pose j = 0
        logic pose_mul;   // form j*dx and j*dy
        logic pose_div_init;
        logic pose_div_step;
        logic pose_next;  // advance j
        logic out_load;   // load the output register with a pose
        logic fin_load;   // load the output register with the final point
        logic commit;     // update the stored previous point
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic have_prev;
        logic is_final;
        logic sqrt_done;
        logic div_done;
        logic n_zero;
        logic norm_done;
        logic cor_done;
        logic pose_div_done;
        logic last_pose;
    } t_stat;

    function automatic logic [25:0] atan_entry(input logic [4:0] idx);
        logic [25:0] v;
        case (idx)
            5'd0:  v = 26'd13176795;
            5'd1:  v = 26'd7778716;
            5'd2:  v = 26'd4110060;
            5'd3:  v = 26'd2086331;
            5'd4:  v = 26'd1047214;
            5'd5:  v = 26'd524117;
            5'd6:  v = 26'd262123;
            5'd7:  v = 26'd131069;
            5'd8:  v = 26'd65536;
            5'd9:  v = 26'd32768;
            5'd10: v = 26'd16384;
            5'd11: v = 26'd8192;
            5'd12: v = 26'd4096;
            5'd13: v = 26'd2048;
            5'd14: v = 26'd1024;
            5'd15: v = 26'd512;
            5'd16: v = 26'd256;
            5'd17: v = 26'd128;
            5'd18: v = 26'd64;
            5'd19: v = 26'd32;
            5'd20: v = 26'd16;
            5'd21: v = 26'd8;
            5'd22: v = 26'd4;
            5'd23: v = 26'd2;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/wpi_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint path interpolator controller
// Sequences the square root, divider, CORDIC and pose emission.
// ----------------------------------------------------------------------------
module wpi_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire              i_out_full,
    input  wire              i_out_take,
    input  wpi_pkg::t_stat   i_stat,
    output wpi_pkg::t_cmd    o_cmd
);

    wpi_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register is free when empty or being emptied this cycle.
    logic out_free;
    assign out_free = !i_out_full || i_out_take;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            wpi_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sqrt_init = 1'b1;
                    n_state = wpi_pkg::S_SQRT;
                end
            end
            wpi_pkg::S_SQRT: begin
                if (!i_stat.have_prev) begin
                    n_state = i_stat.is_final ? wpi_pkg::S_FINAL : wpi_pkg::S_IDLE;
                    o_cmd.commit = !i_stat.is_final;
                end else if (i_stat.sqrt_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state = wpi_pkg::S_DIV;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                end
            end
            wpi_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.n_zero) begin
                        n_state = i_stat.is_final ? wpi_pkg::S_FINAL : wpi_pkg::S_IDLE;
                        o_cmd.commit = !i_stat.is_final;
                    end else begin
                        o_cmd.cor_init = 1'b1;
                        n_state = wpi_pkg::S_NORM;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            wpi_pkg::S_NORM: begin
                if (i_stat.norm_done) begin
                    n_state = wpi_pkg::S_CORDIC;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            wpi_pkg::S_CORDIC: begin
                if (i_stat.cor_done) begin
                    o_cmd.emit_init = 1'b1;
                    n_state = wpi_pkg::S_EMIT_MUL;
                end else begin
                    o_cmd.cor_step = 1'b1;
                end
            end
            wpi_pkg::S_EMIT_MUL: begin
                o_cmd.pose_mul = 1'b1;
                n_state = wpi_pkg::S_EMIT_DIV;
            end
            wpi_pkg::S_EMIT_DIV: begin
                o_cmd.pose_div_init = 1'b1;
                n_state = wpi_pkg::S_EMIT_OUT;
            end
            wpi_pkg::S_EMIT_OUT: begin
                if (!i_stat.pose_div_done) begin
                    o_cmd.pose_div_step = 1'b1;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.last_pose) begin
                        n_state = i_stat.is_final ? wpi_pkg::S_FINAL : wpi_pkg::S_IDLE;
                        o_cmd.commit = !i_stat.is_final;
                    end else begin
                        o_cmd.pose_next = 1'b1;
                        n_state = wpi_pkg::S_EMIT_MUL;
                    end
                end
            end
            wpi_pkg::S_FINAL: begin
                if (out_free) begin
                    o_cmd.fin_load = 1'b1;
                    o_cmd.commit = 1'b1;
                    n_state = wpi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wpi_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/wpi_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint path interpolator datapath
// Differences, square root, dividers, CORDIC and the output register.
// ----------------------------------------------------------------------------
module wpi_dp #(
    parameter int MAX_STEPS = wpi_pkg::MAX_STEPS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wpi_pkg::t_cmd      i_cmd,
    output wpi_pkg::t_stat     o_stat,
    input  wire signed [31:0]  i_point_x,
    input  wire signed [31:0]  i_point_y,
    input  wire signed [15:0]  i_point_heading,
    input  wire                i_is_final,
    input  wire        [30:0]  i_step_length,
    input  wire                i_out_take,
    output logic               o_out_full,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [15:0] o_out_heading,
    output logic               o_end_of_run,
    output logic               o_end_of_path
);

    localparam int NW = $clog2(MAX_STEPS + 1);

    // Stored previous point.
    logic signed [31:0] r_prev_x, r_prev_y;
    logic               r_have_prev;
    // Captured input item.
    logic signed [31:0] r_x, r_y;
    logic signed [15:0] r_hd;
    logic               r_fin;
    logic signed [32:0] r_dx, r_dy;

    // Square root: 66-bit radicand, one result bit per cycle.
    logic [65:0] r_rad;
    logic [33:0] r_root;
    logic [35:0] r_rem;
    logic [5:0]  r_sq_cnt;

    // Distance divider: restoring, one quotient bit per cycle.
    logic [32:0] r_dq;
    logic [31:0] r_drem;
    logic [5:0]  r_d_cnt;
    logic [NW-1:0] r_n;

    // CORDIC.
    logic signed [35:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic [4:0]         r_ci;
    logic               r_c_busy;
    logic signed [15:0] r_head;

    // Pose generation.
    logic [NW-1:0]      r_j;
    logic signed [32+NW:0] r_px, r_py;
    logic [32+NW:0]     r_qx, r_qy;
    logic [NW:0]        r_rx, r_ry;
    logic               r_nx, r_ny;
    logic [5:0]         r_p_cnt;
    logic               r_p_busy;

    // Square root trial.
    logic [1:0]  sq_pair;
    logic [35:0] sq_rem, sq_trial;
    assign sq_pair  = r_rad[65:64];
    assign sq_rem   = {r_rem[33:0], sq_pair};
    assign sq_trial = {r_root, 2'b01};

    // Distance divider trial.
    logic [31:0] d_unit, d_shift, d_sub;
    assign d_unit  = (i_step_length == 31'd0) ? 32'd1 : {1'b0, i_step_length};
    assign d_shift = {r_drem[30:0], r_dq[32]};
    assign d_sub   = d_shift - d_unit;

    // Step count saturated to the pose limit.
    logic [32:0] n_sat;
    assign n_sat = (r_dq > 33'(MAX_STEPS)) ? 33'(MAX_STEPS) : r_dq;

    // Squared length of the difference.
    logic [32:0] ax, ay;
    assign ax = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign ay = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    logic [65:0] a2;
    assign a2 = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);

    // CORDIC normalization.
    logic [35:0] cmx, cmy;
    assign cmx = r_cx[35] ? 36'(-r_cx) : 36'(r_cx);
    assign cmy = r_cy[35] ? 36'(-r_cy) : 36'(r_cy);
    logic norm_done;
    assign norm_done = (cmx >= 36'h100000000) || (cmy >= 36'h100000000);

    logic signed [35:0] xs, ys;
    assign xs = r_cx >>> r_ci;
    assign ys = r_cy >>> r_ci;
    logic signed [33:0] atn;
    assign atn = 34'(wpi_pkg::atan_entry(r_ci));

    // CORDIC rounding.
    logic signed [33:0] zr;
    assign zr = (r_cz + 34'sd1024) >>> 11;

    // Pose dividers: magnitude / n, one bit per cycle.
    logic [NW:0] nn, px_sh, py_sh;
    assign nn    = {1'b0, r_n};
    assign px_sh = {r_rx[NW-1:0], r_qx[32+NW]};
    assign py_sh = {r_ry[NW-1:0], r_qy[32+NW]};
    logic signed [32+NW:0] jdx, jdy;
    assign jdx = (33+NW)'(signed'({1'b0, r_j})) * (33+NW)'(r_dx);
    assign jdy = (33+NW)'(signed'({1'b0, r_j})) * (33+NW)'(r_dy);
    logic signed [32+NW:0] qsx, qsy;
    assign qsx = r_nx ? -signed'(r_qx) : signed'(r_qx);
    assign qsy = r_ny ? -signed'(r_qy) : signed'(r_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_c_busy <= 1'b0;
            r_p_busy <= 1'b0;
            o_out_full <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_x   <= i_point_x;
                r_y   <= i_point_y;
                r_hd  <= i_point_heading;
                r_fin <= i_is_final;
                r_dx  <= 33'(i_point_x) - 33'(r_prev_x);
                r_dy  <= 33'(i_point_y) - 33'(r_prev_y);
            end
            // The first step takes the radicand, the next 33 each give one root bit.
            if (i_cmd.sqrt_init) begin
                r_sq_cnt <= '0;
                r_root <= '0;
                r_rem  <= '0;
            end else if (i_cmd.sqrt_step) begin
                if (r_sq_cnt == 6'd0) begin
                    r_rad <= a2;
                end else begin
                    if (sq_rem >= sq_trial) begin
                        r_rem  <= sq_rem - sq_trial;
                        r_root <= {r_root[32:0], 1'b1};
                    end else begin
                        r_rem  <= sq_rem;
                        r_root <= {r_root[32:0], 1'b0};
                    end
                    r_rad <= {r_rad[63:0], 2'b00};
                end
                r_sq_cnt <= r_sq_cnt + 6'd1;
            end
            // Steps 0 to 32 give the quotient bits, step 33 saturates it.
            if (i_cmd.div_init) begin
                r_d_cnt <= '0;
                r_dq <= r_root[32:0];
                r_drem <= '0;
            end else if (i_cmd.div_step) begin
                if (r_d_cnt == 6'd33) begin
                    r_n <= n_sat[NW-1:0];
                end else if (d_shift >= d_unit || r_drem[31]) begin
                    r_drem <= d_sub;
                    r_dq <= {r_dq[31:0], 1'b1};
                end else begin
                    r_drem <= d_shift;
                    r_dq <= {r_dq[31:0], 1'b0};
                end
                r_d_cnt <= r_d_cnt + 6'd1;
            end
            if (i_cmd.cor_init) begin
                r_c_busy <= 1'b1;
                r_ci <= '0;
                if (r_dx[32]) begin
                    r_cx <= 36'(-r_dx);
                    r_cy <= 36'(-r_dy);
                    r_cz <= r_dy[32] ? -wpi_pkg::PI_Z : wpi_pkg::PI_Z;
                end else begin
                    r_cx <= 36'(r_dx);
                    r_cy <= 36'(r_dy);
                    r_cz <= '0;
                end
            end else if (i_cmd.norm_step) begin
                r_cx <= r_cx <<< 1;
                r_cy <= r_cy <<< 1;
            end else if (i_cmd.cor_step) begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atn;
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atn;
                end
                r_ci <= r_ci + 5'd1;
                if (r_ci == 5'd23) begin
                    r_c_busy <= 1'b0;
                end
            end
            if (i_cmd.emit_init) begin
                r_j <= '0;
                r_head <= (zr > wpi_pkg::HEAD_MAX) ? 16'sd25736 :
                          (zr < -wpi_pkg::HEAD_MAX) ? -16'sd25736 : 16'(zr);
            end
            if (i_cmd.pose_mul) begin
                r_px <= jdx;
                r_py <= jdy;
            end
            if (i_cmd.pose_div_init) begin
                r_nx <= r_px[32+NW];
                r_ny <= r_py[32+NW];
                r_qx <= r_px[32+NW] ? unsigned'(-r_px) : unsigned'(r_px);
                r_qy <= r_py[32+NW] ? unsigned'(-r_py) : unsigned'(r_py);
                r_rx <= '0;
                r_ry <= '0;
                r_p_cnt <= '0;
                r_p_busy <= 1'b1;
            end else if (i_cmd.pose_div_step) begin
                if (px_sh >= nn) begin
                    r_rx <= px_sh - nn;
                    r_qx <= {r_qx[31+NW:0], 1'b1};
                end else begin
                    r_rx <= px_sh;
                    r_qx <= {r_qx[31+NW:0], 1'b0};
                end
                if (py_sh >= nn) begin
                    r_ry <= py_sh - nn;
                    r_qy <= {r_qy[31+NW:0], 1'b1};
                end else begin
                    r_ry <= py_sh;
                    r_qy <= {r_qy[31+NW:0], 1'b0};
                end
                r_p_cnt <= r_p_cnt + 6'd1;
                if (r_p_cnt == 6'(32 + NW)) begin
                    r_p_busy <= 1'b0;
                end
            end
            if (i_cmd.pose_next) begin
                r_j <= r_j + 1'b1;
            end
            if (i_out_take) begin
                o_out_full <= 1'b0;
            end
            if (i_cmd.out_load) begin
                o_out_full    <= 1'b1;
                o_out_x       <= r_prev_x + qsx[31:0];
                o_out_y       <= r_prev_y + qsy[31:0];
                o_out_heading <= r_head;
                o_end_of_run  <= o_stat.last_pose && !r_fin;
                o_end_of_path <= 1'b0;
            end else if (i_cmd.fin_load) begin
                o_out_full    <= 1'b1;
                o_out_x       <= r_x;
                o_out_y       <= r_y;
                o_out_heading <= r_hd;
                o_end_of_run  <= 1'b1;
                o_end_of_path <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_have_prev <= !r_fin;
                r_prev_x <= r_fin ? 32'sd0 : r_x;
                r_prev_y <= r_fin ? 32'sd0 : r_y;
            end
        end
    end

    always_comb begin
        o_stat.have_prev     = r_have_prev;
        o_stat.is_final      = r_fin;
        o_stat.sqrt_done     = (r_sq_cnt == 6'd34);
        o_stat.div_done      = (r_d_cnt == 6'd34);
        o_stat.n_zero        = (r_n == '0);
        o_stat.norm_done     = norm_done;
        o_stat.cor_done      = !r_c_busy;
        o_stat.pose_div_done = !r_p_busy;
        o_stat.last_pose     = (r_j == r_n - 1'b1);
    end

endmodule
`default_nettype wire

[rtl/waypoint_path_interpolator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint path interpolator
// Splits each path segment into equal steps with a CORDIC heading.
// ----------------------------------------------------------------------------
// A segment waypoint passes through the square root, the step count division,
// normalizing and the CORDIC before its first pose; each pose then passes the
// serial pose divider and waits for the output register to be free. A waypoint
// with no stored predecessor only becomes the stored point (or, if final, is
// sent as the end of path). One item at a time. Reset (synchronous, active
// low) clears the stored point and the step length returns to its reset value.
module waypoint_path_interpolator #(
    parameter int MAX_STEPS = wpi_pkg::MAX_STEPS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire        [30:0]  i_step_length,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire signed [31:0]  i_point_x,
    input  wire signed [31:0]  i_point_y,
    input  wire signed [15:0]  i_point_heading,
    input  wire                i_is_final,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [15:0] o_out_heading,
    output logic               o_end_of_run,
    output logic               o_end_of_path
);

    // Step length register; writes are always accepted.
    logic [30:0] r_step;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= wpi_pkg::STEP_RESET;
        end else if (i_cfg_valid) begin
            r_step <= i_step_length;
        end
    end

    wpi_pkg::t_cmd  cmd;
    wpi_pkg::t_stat stat;
    logic out_full, out_take;
    assign o_out_valid = out_full;
    assign out_take = out_full && i_out_ready;

    wpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_full (out_full),
        .i_out_take (out_take),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wpi_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_heading (i_point_heading),
        .i_is_final      (i_is_final),
        .i_step_length   (r_step),
        .i_out_take      (out_take),
        .o_out_full      (out_full),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_heading   (o_out_heading),
        .o_end_of_run    (o_end_of_run),
        .o_end_of_path   (o_end_of_path)
    );

endmodule
`default_nettype wire
